@@ rtl/cpe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the complex polynomial evaluator.
// No dependencies; imported by the controller, the datapath and the top level.
package cpe_pkg;

    // Fixed widths of the fixed-point data and the item fields.
    localparam int DATA_W        = 32;
    localparam int FRAC_W        = 16;
    localparam int COUNT_W       = 7;
    localparam int IDX_W         = 6;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int MAX_COEFS_DEF = 64;

    // One in Q16.16.
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    // Register index decoded from the word address bit of paddr.
    localparam logic REG_COEF_COUNT = 1'b0;

    // Item function codes.
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch point, clear accumulator, set power to one
        logic load;      // write one coefficient into the store
        logic issue_p;   // issue x * p into the shared complex multiplier
        logic issue_t;   // issue p * coef into the shared complex multiplier
        logic cnt_inc;   // step to the next coefficient
        logic out_load;  // copy accumulator and flag into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;    // no coefficients in use
        logic last;      // current coefficient is the last one
        logic pipe_idle; // multiplier and accumulator stages are empty
    } t_stat;

    // Saturated value with its overflow flag.
    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } t_sat;

    // Saturate a shifted 49-bit product component to 32 bits.
    function automatic t_sat sat_prod(input logic [48:0] v);
        t_sat r;
        r.ovf = !((&v[48:31]) || (~|v[48:31]));
        if (r.ovf) begin
            r.val = v[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Saturate a 33-bit sum to 32 bits.
    function automatic t_sat sat_sum(input logic [32:0] v);
        t_sat r;
        r.ovf = (v[32] != v[31]);
        if (r.ovf) begin
            r.val = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/cpe_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine for the complex polynomial evaluator.
// Depends on cpe_pkg for the command and status structs.
module cpe_ctrl
    import cpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [0:0] i_func,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHP,
        S_PHT,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state and per-cycle commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_func == FUNC_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_PHP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            // Power phase: step the power unless last term; with no terms, finish.
            S_PHP: begin
                if (i_stat.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.issue_p = !i_stat.last;
                    n_state       = S_PHT;
                end
            end
            // Term phase: multiply the power by the coefficient just read.
            S_PHT: begin
                o_cmd.issue_t = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_PHP;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_idle) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid follows the output register load and the consumer taking it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/cpe_dp.sv @@
`timescale 1ns / 1ps
// Datapath: coefficient store, shared two-stage complex multiplier, accumulator
// and output register. Depends on cpe_pkg for widths, commands and saturation.
module cpe_dp
    import cpe_pkg::*;
#(
    parameter int MAX_COEFS = MAX_COEFS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [COUNT_W-1:0]       i_coef_count,
    input  logic [IDX_W-1:0]         i_coef_index,
    input  logic signed [DATA_W-1:0] i_value_re,
    input  logic signed [DATA_W-1:0] i_value_im,
    output logic signed [DATA_W-1:0] o_result_re,
    output logic signed [DATA_W-1:0] o_result_im,
    output logic                     o_overflow
);

    localparam int AW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int CW = $clog2(MAX_COEFS + 1);

    // Coefficient store, {re, im} per entry.
    logic [2*DATA_W-1:0] mem [MAX_COEFS];
    logic [2*DATA_W-1:0] r_rd_coef;

    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_n;

    logic signed [DATA_W-1:0] r_x_re, r_x_im;
    logic signed [DATA_W-1:0] r_p_re, r_p_im;
    logic signed [DATA_W-1:0] r_term_re, r_term_im;
    logic signed [DATA_W-1:0] r_acc_re, r_acc_im;
    logic                     r_ovf;
    logic                     n_ovf;

    // Multiplier stage one: four real products and a tag for the destination.
    logic signed [2*DATA_W-1:0] r_pr_rr, r_pr_ii, r_pr_ri, r_pr_ir;
    logic                       r_s1_vld;
    logic                       r_s1_pow;
    logic                       r_term_vld;

    logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;
    logic signed [2*DATA_W:0] sum_re, sum_im;
    logic signed [DATA_W:0]   acc_re_sum, acc_im_sum;
    t_sat                     m_re, m_im, s_re, s_im;
    logic                     load_hit;

    // Status for the controller.
    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.last      = ((CW+1)'(r_idx) + (CW+1)'(1)) == (CW+1)'(r_n);
    assign o_stat.pipe_idle = !r_s1_vld && !r_term_vld;

    assign load_hit = i_cmd.load && (32'(i_coef_index) < MAX_COEFS);

    // Store write on a load item; read of the current coefficient every cycle.
    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            mem[AW'(i_coef_index)] <= {i_value_re, i_value_im};
        end
        r_rd_coef <= mem[r_idx[AW-1:0]];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        if (i_cmd.issue_p) begin
            a_re = r_x_re;
            a_im = r_x_im;
            b_re = r_p_re;
            b_im = r_p_im;
        end else begin
            a_re = r_p_re;
            a_im = r_p_im;
            b_re = $signed(r_rd_coef[2*DATA_W-1:DATA_W]);
            b_im = $signed(r_rd_coef[DATA_W-1:0]);
        end
    end

    // Multiplier stage two: combine, floor shift and saturate.
    always_comb begin
        sum_re = (2*DATA_W+1)'(r_pr_rr) - (2*DATA_W+1)'(r_pr_ii);
        sum_im = (2*DATA_W+1)'(r_pr_ri) + (2*DATA_W+1)'(r_pr_ir);
        m_re   = sat_prod(sum_re[2*DATA_W:FRAC_W]);
        m_im   = sat_prod(sum_im[2*DATA_W:FRAC_W]);
    end

    // Accumulator add with saturation.
    always_comb begin
        acc_re_sum = (DATA_W+1)'(r_acc_re) + (DATA_W+1)'(r_term_re);
        acc_im_sum = (DATA_W+1)'(r_acc_im) + (DATA_W+1)'(r_term_im);
        s_re       = sat_sum(acc_re_sum);
        s_im       = sat_sum(acc_im_sum);
    end

    // Overflow collects every saturating product and sum of this evaluation.
    always_comb begin
        n_ovf = r_ovf;
        if (r_s1_vld) begin
            n_ovf = n_ovf | m_re.ovf | m_im.ovf;
        end
        if (r_term_vld) begin
            n_ovf = n_ovf | s_re.ovf | s_im.ovf;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_term_vld <= 1'b0;
        end else begin
            r_s1_vld   <= i_cmd.issue_p || i_cmd.issue_t;
            r_term_vld <= r_s1_vld && !r_s1_pow;
        end
    end

    // Products, running power, term, accumulator and counters.
    always_ff @(posedge i_clk) begin
        r_s1_pow <= i_cmd.issue_p;
        if (i_cmd.issue_p || i_cmd.issue_t) begin
            r_pr_rr <= a_re * b_re;
            r_pr_ii <= a_im * b_im;
            r_pr_ri <= a_re * b_im;
            r_pr_ir <= a_im * b_re;
        end
        if (i_cmd.start) begin
            r_x_re   <= i_value_re;
            r_x_im   <= i_value_im;
            r_p_re   <= Q_ONE;
            r_p_im   <= '0;
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            if (32'(i_coef_count) > MAX_COEFS) begin
                r_n <= CW'(MAX_COEFS);
            end else begin
                r_n <= CW'(i_coef_count);
            end
        end else begin
            r_ovf <= n_ovf;
            if (r_s1_vld && r_s1_pow) begin
                r_p_re <= m_re.val;
                r_p_im <= m_im.val;
            end
            if (r_s1_vld && !r_s1_pow) begin
                r_term_re <= m_re.val;
                r_term_im <= m_im.val;
            end
            if (r_term_vld) begin
                r_acc_re <= s_re.val;
                r_acc_im <= s_im.val;
            end
            if (i_cmd.cnt_inc) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    // Output register, loaded once the evaluation has drained.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_re <= r_acc_re;
            o_result_im <= r_acc_im;
            o_overflow  <= r_ovf;
        end
    end

endmodule

@@ rtl/complex_polynomial_evaluator.sv @@
`timescale 1ns / 1ps
// Top level of the complex polynomial evaluator: configuration register, APB
// port, controller and datapath. Depends on cpe_pkg, cpe_ctrl and cpe_dp.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-----------------------------------------
//   input    | i_in_valid / o_in_ready    | i_func, i_coef_index, i_value_re/_im
//   output   | o_out_valid / i_out_ready  | o_result_re, o_result_im, o_overflow
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata (coef_count at 0)
//
// A load item leaves the controller idle, so the next item can follow. An evaluate
// item with N = min(coef_count, MAX_COEFS) uses the one shared complex multiplier
// for a term product per coefficient and a power product per coefficient but the
// last, then drains the pipeline and loads the output; with N zero it only loads.
// Reset is synchronous and active low; the coefficient store is not cleared.
// A finished result waits in the output register while load items keep flowing;
// a new evaluate item is taken only after the previous result has been loaded.
module complex_polynomial_evaluator
    import cpe_pkg::*;
#(
    parameter int MAX_COEFS = MAX_COEFS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [0:0]                i_func,
    input  logic [IDX_W-1:0]          i_coef_index,
    input  logic signed [DATA_W-1:0]  i_value_re,
    input  logic signed [DATA_W-1:0]  i_value_im,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DATA_W-1:0]  o_result_re,
    output logic signed [DATA_W-1:0]  o_result_im,
    output logic                      o_overflow,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    logic [COUNT_W-1:0] r_coef_count;
    logic               cfg_write;
    t_cmd               cmd;
    t_stat              stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_count <= '0;
        end else if (cfg_write && (paddr[2] == REG_COEF_COUNT)) begin
            r_coef_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Register read back.
    always_comb begin
        if (paddr[2] == REG_COEF_COUNT) begin
            prdata = PDATA_W'(r_coef_count);
        end else begin
            prdata = '0;
        end
    end

    cpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cpe_dp #(
        .MAX_COEFS (MAX_COEFS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_coef_count (r_coef_count),
        .i_coef_index (i_coef_index),
        .i_value_re   (i_value_re),
        .i_value_im   (i_value_im),
        .o_result_re  (o_result_re),
        .o_result_im  (o_result_im),
        .o_overflow   (o_overflow)
    );

endmodule
